@@ rtl/core/mdo_pkg.sv @@
`default_nettype none
package mdo_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 24;
  localparam int GAIN_W    = 32;
  localparam int ALPHA_W   = 25;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LANES = 6;
  // Multiplier operands hold a 33-bit signed value or a zero-extended gain, step time or smoothing factor.
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [ALPHA_W-1:0] ONE_Q = ALPHA_W'(1) << FRAC_BITS;

  localparam logic [STEP_W-1:0]  STEP_TIME_RST   = STEP_W'(67109);
  localparam logic [GAIN_W-1:0]  FORCE_GAIN_RST  = GAIN_W'(83886080);
  localparam logic [GAIN_W-1:0]  TORQUE_GAIN_RST = GAIN_W'(335544320);
  localparam logic [GAIN_W-1:0]  FORCE_CORR_RST  = GAIN_W'(33554432);
  localparam logic [GAIN_W-1:0]  TORQUE_CORR_RST = GAIN_W'(167772160);
  localparam logic [ALPHA_W-1:0] SMOOTHING_RST   = ALPHA_W'(3355443);
  localparam logic [MODE_W-1:0]  MODE_RST        = MODE_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME   = 3'd0,
    REG_FORCE_GAIN  = 3'd1,
    REG_TORQUE_GAIN = 3'd2,
    REG_FORCE_CORR  = 3'd3,
    REG_TORQUE_CORR = 3'd4,
    REG_SMOOTHING   = 3'd5,
    REG_MODE        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] lin_mom_x;
    logic signed [DATA_W-1:0] lin_mom_y;
    logic signed [DATA_W-1:0] lin_mom_z;
    logic signed [DATA_W-1:0] ang_mom_x;
    logic signed [DATA_W-1:0] ang_mom_y;
    logic signed [DATA_W-1:0] ang_mom_z;
    logic signed [DATA_W-1:0] net_force_x;
    logic signed [DATA_W-1:0] net_force_y;
    logic signed [DATA_W-1:0] net_force_z;
    logic signed [DATA_W-1:0] net_torque_x;
    logic signed [DATA_W-1:0] net_torque_y;
    logic signed [DATA_W-1:0] net_torque_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ext_force_x;
    logic signed [DATA_W-1:0] ext_force_y;
    logic signed [DATA_W-1:0] ext_force_z;
    logic signed [DATA_W-1:0] ext_torque_x;
    logic signed [DATA_W-1:0] ext_torque_y;
    logic signed [DATA_W-1:0] ext_torque_z;
  } out_item_t;

  // Settings shared by every lane.
  typedef struct packed {
    logic [STEP_W-1:0]  step_time;
    logic [ALPHA_W-1:0] alpha;
    logic               use_corr;
    logic               integrate;
  } lane_cfg_t;

  function automatic logic signed [DATA_W-1:0] sat_wide(
      input logic signed [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1]) begin
      return v[DATA_W] ? Q_MIN : Q_MAX;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat_wide(s);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return sat_wide(s);
  endfunction

  // Product scaled back by FRAC_BITS, rounded half up, then clamped.
  function automatic logic signed [DATA_W-1:0] mul_round(
      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] sh;
    t  = p + HALF_Q;
    sh = t >>> FRAC_BITS;
    if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1])) begin
      return sh[DATA_W-1:0];
    end
    return sh[PROD_W-1] ? Q_MIN : Q_MAX;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/momentum_disturbance_observer.sv @@
// Each lane steps through RES, MQ, Q, NET, MD, EST, MS and SM per transaction;
// mode[1] adds MDI and DI, mode[0] adds MC and C. Six axis lanes run in lockstep,
// each through one shared multiplier whose product is registered before use.
// A new transaction is taken only once the last result is in the output register.
// Reset (rst, synchronous): registers return to their defaults, all estimates clear.
`default_nettype none
module momentum_disturbance_observer (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire mdo_pkg::in_item_t                      in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output mdo_pkg::out_item_t                          out_data,
  input  wire logic                                   cfg_en,
  input  wire logic [mdo_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mdo_pkg::GAIN_W-1:0]             cfg_data
);
  import mdo_pkg::*;

  logic [STEP_W-1:0]  step_time;
  logic [GAIN_W-1:0]  force_gain;
  logic [GAIN_W-1:0]  torque_gain;
  logic [GAIN_W-1:0]  force_corr;
  logic [GAIN_W-1:0]  torque_corr;
  logic [ALPHA_W-1:0] smoothing;
  logic [MODE_W-1:0]  mode;

  lane_cfg_t lane_cfg;
  logic      start;

  logic signed [DATA_W-1:0] meas_in     [NUM_LANES];
  logic signed [DATA_W-1:0] net_in      [NUM_LANES];
  logic        [GAIN_W-1:0] lane_gain   [NUM_LANES];
  logic        [GAIN_W-1:0] lane_corr   [NUM_LANES];
  logic signed [DATA_W-1:0] lane_smooth [NUM_LANES];
  logic [NUM_LANES-1:0]     lane_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= STEP_TIME_RST;
      force_gain  <= FORCE_GAIN_RST;
      torque_gain <= TORQUE_GAIN_RST;
      force_corr  <= FORCE_CORR_RST;
      torque_corr <= TORQUE_CORR_RST;
      smoothing   <= SMOOTHING_RST;
      mode        <= MODE_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_STEP_TIME:   step_time   <= cfg_data[STEP_W-1:0];
        REG_FORCE_GAIN:  force_gain  <= cfg_data;
        REG_TORQUE_GAIN: torque_gain <= cfg_data;
        REG_FORCE_CORR:  force_corr  <= cfg_data;
        REG_TORQUE_CORR: torque_corr <= cfg_data;
        REG_SMOOTHING:   smoothing   <= cfg_data[ALPHA_W-1:0];
        REG_MODE:        mode        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // A smoothing factor above one acts as exactly one.
  assign lane_cfg.step_time = step_time;
  assign lane_cfg.alpha     = (smoothing > ONE_Q) ? ONE_Q : smoothing;
  assign lane_cfg.use_corr  = mode[0];
  assign lane_cfg.integrate = mode[1];

  assign start = in_valid && in_ready;

  assign meas_in[0] = in_data.lin_mom_x;
  assign meas_in[1] = in_data.lin_mom_y;
  assign meas_in[2] = in_data.lin_mom_z;
  assign meas_in[3] = in_data.ang_mom_x;
  assign meas_in[4] = in_data.ang_mom_y;
  assign meas_in[5] = in_data.ang_mom_z;
  assign net_in[0]  = in_data.net_force_x;
  assign net_in[1]  = in_data.net_force_y;
  assign net_in[2]  = in_data.net_force_z;
  assign net_in[3]  = in_data.net_torque_x;
  assign net_in[4]  = in_data.net_torque_y;
  assign net_in[5]  = in_data.net_torque_z;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    // The first half of the lanes carry the linear axes.
    assign lane_gain[i] = (i < NUM_LANES / 2) ? force_gain : torque_gain;
    assign lane_corr[i] = (i < NUM_LANES / 2) ? force_corr : torque_corr;

    mdo_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .start     (start),
      .meas_in   (meas_in[i]),
      .net_in    (net_in[i]),
      .gain      (lane_gain[i]),
      .corr_gain (lane_corr[i]),
      .cfg       (lane_cfg),
      .done      (lane_done[i]),
      .smooth    (lane_smooth[i])
    );
  end

  mdo_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .lane_done   (lane_done),
    .lane_smooth (lane_smooth),
    .out_ready   (out_ready),
    .idle        (in_ready),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  // All lanes run the same schedule, so they finish together.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_done == '0) || (lane_done == '1))
    else $error("axis lanes finished in different cycles");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    (|lane_done) |-> !in_ready)
    else $error("lane finished while no transaction was in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input taken again before the lanes finished");

endmodule
`default_nettype wire

@@ rtl/core/mdo_lane.sv @@
`default_nettype none
module mdo_lane (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [mdo_pkg::DATA_W-1:0]      meas_in,
  input  wire logic signed [mdo_pkg::DATA_W-1:0]      net_in,
  input  wire logic        [mdo_pkg::GAIN_W-1:0]      gain,
  input  wire logic        [mdo_pkg::GAIN_W-1:0]      corr_gain,
  input  wire mdo_pkg::lane_cfg_t                     cfg,
  output logic                                        done,
  output logic signed [mdo_pkg::DATA_W-1:0]           smooth
);
  import mdo_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RES  = 13'b0000000000010,
    ST_MQ   = 13'b0000000000100,
    ST_Q    = 13'b0000000001000,
    ST_MDI  = 13'b0000000010000,
    ST_DI   = 13'b0000000100000,
    ST_NET  = 13'b0000001000000,
    ST_MC   = 13'b0000010000000,
    ST_C    = 13'b0000100000000,
    ST_MD   = 13'b0001000000000,
    ST_EST  = 13'b0010000000000,
    ST_MS   = 13'b0100000000000,
    ST_SM   = 13'b1000000000000
  } lane_state_t;

  lane_state_t state, state_next;

  logic signed [DATA_W-1:0] est;
  logic signed [DATA_W-1:0] disturb;
  logic signed [DATA_W-1:0] meas;
  logic signed [DATA_W-1:0] net;
  logic signed [DATA_W-1:0] r;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] d;
  logic signed [PROD_W-1:0] prod;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [DATA_W:0]   smooth_diff;
  logic signed [DATA_W-1:0] mq;

  assign smooth_diff = {disturb[DATA_W-1], disturb} - {smooth[DATA_W-1], smooth};
  assign mq   = mul_round(prod);
  assign done = (state == ST_SM);

  // One shared multiplier; its operands follow the step being issued.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MQ: begin
        mul_a = {r[DATA_W-1], r};
        mul_b = {(MUL_W-GAIN_W)'(0), gain};
      end
      ST_MDI: begin
        mul_a = {q[DATA_W-1], q};
        mul_b = {(MUL_W-STEP_W)'(0), cfg.step_time};
      end
      ST_MC: begin
        mul_a = {r[DATA_W-1], r};
        mul_b = {(MUL_W-GAIN_W)'(0), corr_gain};
      end
      ST_MD: begin
        mul_a = {d[DATA_W-1], d};
        mul_b = {(MUL_W-STEP_W)'(0), cfg.step_time};
      end
      ST_MS: begin
        mul_a = smooth_diff;
        mul_b = {(MUL_W-ALPHA_W)'(0), cfg.alpha};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_RES;
      ST_RES:  state_next = ST_MQ;
      ST_MQ:   state_next = ST_Q;
      ST_Q:    state_next = cfg.integrate ? ST_MDI : ST_NET;
      ST_MDI:  state_next = ST_DI;
      ST_DI:   state_next = ST_NET;
      ST_NET:  state_next = cfg.use_corr ? ST_MC : ST_MD;
      ST_MC:   state_next = ST_C;
      ST_C:    state_next = ST_MD;
      ST_MD:   state_next = ST_EST;
      ST_EST:  state_next = ST_MS;
      ST_MS:   state_next = ST_SM;
      ST_SM:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      est     <= '0;
      disturb <= '0;
      smooth  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_Q && !cfg.integrate) disturb <= mq;
      if (state == ST_DI)  disturb <= sat_add(disturb, mq);
      if (state == ST_EST) est     <= sat_add(est, mq);
      if (state == ST_SM)  smooth  <= sat_add(smooth, mq);
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (state == ST_IDLE && start) begin
      meas <= meas_in;
      net  <= net_in;
    end
    if (state == ST_RES) r <= sat_sub(meas, est);
    if (state == ST_Q)   q <= mq;
    if (state == ST_NET) d <= sat_add(net, disturb);
    if (state == ST_C)   d <= sat_add(d, mq);
  end

endmodule
`default_nettype wire

@@ rtl/core/mdo_merge.sv @@
`default_nettype none
module mdo_merge (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [mdo_pkg::NUM_LANES-1:0]          lane_done,
  input  wire logic signed [mdo_pkg::DATA_W-1:0]      lane_smooth [mdo_pkg::NUM_LANES],
  input  wire logic                                   out_ready,
  output logic                                        idle,
  output logic                                        out_valid,
  output mdo_pkg::out_item_t                          out_data
);
  import mdo_pkg::*;

  logic busy;
  logic pending;
  logic load;

  // A finished result waits here until the output register is free.
  assign load = pending && (!out_valid || out_ready);
  assign idle = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) busy <= 1'b1;
      else if (load) busy <= 1'b0;
      if (&lane_done) pending <= 1'b1;
      else if (load) pending <= 1'b0;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.ext_force_x  <= lane_smooth[0];
      out_data.ext_force_y  <= lane_smooth[1];
      out_data.ext_force_z  <= lane_smooth[2];
      out_data.ext_torque_x <= lane_smooth[3];
      out_data.ext_torque_y <= lane_smooth[4];
      out_data.ext_torque_z <= lane_smooth[5];
    end
  end

endmodule
`default_nettype wire
